// File: rtl/aacc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aacc_pkg: shared types and constants of the ANSI-aware column clipper
// Holds the byte codes, the clip state encoding, the structs that travel
// between the step logic, the result queue and the top level, and the
// per-byte classification function.
// ----------------------------------------------------------------------------
package aacc_pkg;

  // Widths of the fields.
  localparam int WidthW = 10;
  localparam int ByteW  = 8;

  // Largest column width the block will honor.
  localparam logic [WidthW-1:0] MaxColumnWidth = 10'd1023;

  // Byte codes.
  localparam logic [ByteW-1:0] EscByte   = 8'h1B;
  localparam logic [ByteW-1:0] OpenByte  = 8'h5B;
  localparam logic [ByteW-1:0] CloseByte = 8'h6D;
  localparam logic [ByteW-1:0] LfByte    = 8'h0A;
  localparam logic [ByteW-1:0] CrByte    = 8'h0D;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] NulByte   = 8'h00;

  // Item kinds.
  localparam logic KindText = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CfgColumnWidth = 2'd0;
  localparam logic [1:0] CfgPadEnable   = 2'd1;
  localparam logic [1:0] CfgKeepEscapes = 2'd2;

  // Result queue geometry.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  typedef enum logic [1:0] {
    ClipAccept = 2'd0,
    ClipTrail  = 2'd1,
    ClipDone   = 2'd2
  } clip_mode_t;

  typedef struct packed {
    logic              in_escape;
    logic              esc_held;
    logic [WidthW-1:0] shown_count;
    logic              escape_seen;
    clip_mode_t        clip_mode;
  } aacc_state_t;

  typedef struct packed {
    logic [WidthW-1:0] column_width;
    logic              pad_enable;
    logic              keep_escapes;
  } aacc_cfg_t;

  typedef struct packed {
    logic              char_valid;
    logic [ByteW-1:0]  out_char;
    logic [WidthW-1:0] pad_spaces;
    logic              reset_needed;
    logic              line_done;
  } aacc_res_t;

  typedef struct packed {
    logic              emit;
    logic [WidthW-1:0] shown_count;
    clip_mode_t        clip_mode;
  } aacc_plain_t;

  function automatic logic is_cont(input logic [ByteW-1:0] c);
    return (c & ContMask) == ContTag;
  endfunction

  function automatic aacc_res_t char_res(input logic [ByteW-1:0] c);
    aacc_res_t r;
    r.char_valid   = 1'b1;
    r.out_char     = c;
    r.pad_spaces   = '0;
    r.reset_needed = 1'b0;
    r.line_done    = 1'b0;
    return r;
  endfunction

  // One byte outside any escape, while the column still accepts.
  function automatic aacc_plain_t plain_byte(input logic [ByteW-1:0]  c,
                                             input logic [WidthW-1:0] shown,
                                             input logic [WidthW-1:0] width);
    aacc_plain_t p;
    p.emit        = 1'b0;
    p.shown_count = shown;
    p.clip_mode   = ClipAccept;
    if (c != LfByte && c != CrByte) begin
      if (shown >= width) begin
        if (is_cont(c)) begin
          p.emit      = 1'b1;
          p.clip_mode = ClipTrail;
        end else begin
          p.clip_mode = ClipDone;
        end
      end else begin
        p.emit = 1'b1;
        if (!is_cont(c)) begin
          p.shown_count = shown + 10'd1;
        end
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/aacc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aacc_step: per-item decision logic
// From the line state, the registers and one item, works out the next line
// state and up to two results, in order.
// ----------------------------------------------------------------------------
module aacc_step (
  input  wire logic                            kind,
  input  wire logic [aacc_pkg::ByteW-1:0]      text_byte,
  input  wire aacc_pkg::aacc_state_t           st,
  input  wire aacc_pkg::aacc_cfg_t             cfg,
  output aacc_pkg::aacc_state_t                st_nxt,
  output logic [1:0]                           res_cnt,
  output aacc_pkg::aacc_res_t                  res0,
  output aacc_pkg::aacc_res_t                  res1
);

  logic [aacc_pkg::WidthW-1:0] width;
  logic [aacc_pkg::WidthW-1:0] sh;
  logic                        a_v;
  logic                        b_v;
  logic                        go;
  aacc_pkg::aacc_res_t         a_res;
  aacc_pkg::aacc_res_t         b_res;
  aacc_pkg::aacc_plain_t       p;

  assign width = (cfg.column_width > aacc_pkg::MaxColumnWidth) ?
                 aacc_pkg::MaxColumnWidth : cfg.column_width;

  always_comb begin
    st_nxt = st;
    a_v    = 1'b0;
    b_v    = 1'b0;
    go     = 1'b0;
    sh     = st.shown_count;
    a_res  = aacc_pkg::char_res(aacc_pkg::EscByte);
    b_res  = aacc_pkg::char_res(text_byte);
    p      = aacc_pkg::plain_byte(text_byte, st.shown_count, width);
    if (kind == aacc_pkg::KindEnd) begin
      // A held ESC that meets the end of line is an ordinary character.
      if (st.esc_held && st.clip_mode == aacc_pkg::ClipAccept) begin
        p   = aacc_pkg::plain_byte(aacc_pkg::EscByte, st.shown_count, width);
        a_v = p.emit;
        sh  = p.shown_count;
      end
      b_v                = 1'b1;
      b_res.char_valid   = 1'b0;
      b_res.out_char     = '0;
      b_res.pad_spaces   = (cfg.pad_enable && sh < width) ? width - sh : '0;
      b_res.reset_needed = st.escape_seen & cfg.keep_escapes;
      b_res.line_done    = 1'b1;
      st_nxt             = '0;
    end else if (text_byte != aacc_pkg::NulByte) begin
      unique case (st.clip_mode)
        aacc_pkg::ClipDone: begin
        end
        aacc_pkg::ClipTrail: begin
          if (aacc_pkg::is_cont(text_byte)) begin
            b_v = 1'b1;
          end else begin
            st_nxt.clip_mode = aacc_pkg::ClipDone;
          end
        end
        aacc_pkg::ClipAccept: begin
          if (st.in_escape) begin
            if (text_byte == aacc_pkg::CloseByte) begin
              st_nxt.in_escape = 1'b0;
            end
            b_v = cfg.keep_escapes;
          end else begin
            go = 1'b1;
            if (st.esc_held) begin
              st_nxt.esc_held = 1'b0;
              if (text_byte == aacc_pkg::OpenByte) begin
                st_nxt.in_escape   = 1'b1;
                st_nxt.escape_seen = 1'b1;
                a_v = cfg.keep_escapes;
                b_v = cfg.keep_escapes;
                go  = 1'b0;
              end else if (st.shown_count >= width) begin
                // The held ESC lands on a full column and closes it.
                st_nxt.clip_mode = aacc_pkg::ClipDone;
                go = 1'b0;
              end else begin
                a_v = 1'b1;
                sh  = st.shown_count + 10'd1;
              end
            end
            if (go) begin
              if (text_byte == aacc_pkg::EscByte) begin
                st_nxt.esc_held    = 1'b1;
                st_nxt.shown_count = sh;
              end else begin
                p = aacc_pkg::plain_byte(text_byte, sh, width);
                b_v                = p.emit;
                st_nxt.shown_count = p.shown_count;
                st_nxt.clip_mode   = p.clip_mode;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_cnt = {1'b0, a_v} + {1'b0, b_v};
  assign res0    = a_v ? a_res : b_res;
  assign res1    = b_res;

endmodule
`default_nettype wire

// File: rtl/aacc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aacc_fifo: result queue
// Small register queue that takes up to two results a cycle and hands out
// one result a cycle on the output channel while the output is not stalled.
// ----------------------------------------------------------------------------
module aacc_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [1:0]           push_cnt,
  input  wire aacc_pkg::aacc_res_t  push0,
  input  wire aacc_pkg::aacc_res_t  push1,
  input  wire logic                 pop,
  output logic                      head_valid,
  output aacc_pkg::aacc_res_t       head,
  output logic                      room2
);

  aacc_pkg::aacc_res_t               mem [aacc_pkg::FifoDepth];
  logic [aacc_pkg::FifoPtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [aacc_pkg::FifoPtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [aacc_pkg::FifoCntW-1:0]     count_r, count_nxt;
  logic [aacc_pkg::FifoPtrW-1:0]     wr_ptr_p1;
  logic                              do_pop;

  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign room2      = (count_r <= 3'(aacc_pkg::FifoDepth - 2));
  assign do_pop     = pop & head_valid;
  assign wr_ptr_p1  = wr_ptr_r + 2'd1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    count_nxt  = count_r + {1'b0, push_cnt} - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(aacc_pkg::FifoDepth))
    else $error("result queue count beyond its depth");
`endif

endmodule
`default_nettype wire

// File: rtl/ansi_aware_column_clipper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_aware_column_clipper: fits one text line into a display column
// Path: an accepted item is held in the input register, and its results are
//   written into the result queue, whose head drives the output channel.
// Throughput: one item per cycle while the queue has room for two results;
//   the output channel moves one result per cycle while out_stall is low.
// Reset (rst_n low, synchronous) clears the line state, empties the result
//   queue and loads the registers with width 80, padding on, escapes kept.
// ----------------------------------------------------------------------------
module ansi_aware_column_clipper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel: one byte or one end-of-line marker per item.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_text_byte,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_char_valid,
  output logic [7:0]       out_char,
  output logic [9:0]       out_pad_spaces,
  output logic             out_reset_needed,
  output logic             out_line_done,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  // Configuration registers.
  aacc_pkg::aacc_cfg_t   cfg_r;

  // Input register: the item waiting to be processed.
  logic                  in_vld_r, in_vld_nxt;
  logic                  in_kind_r;
  logic [7:0]            in_byte_r;

  // Line state.
  aacc_pkg::aacc_state_t st_r, st_nxt;

  // Step logic results.
  logic [1:0]            res_cnt;
  aacc_pkg::aacc_res_t   res0;
  aacc_pkg::aacc_res_t   res1;

  // Queue side.
  logic                  q_valid;
  logic                  q_room2;
  aacc_pkg::aacc_res_t   q_head;

  logic                  in_accept;
  logic                  advance;

  // The held item moves on once the queue has room for both of its results.
  assign advance   = in_vld_r & q_room2;
  assign in_stall  = in_vld_r & ~q_room2;
  assign in_accept = in_valid & ~in_stall;

  // Writes are to be issued only while the block is idle; the block itself does not enforce this and always takes them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_width <= 10'd80;
      cfg_r.pad_enable   <= 1'b1;
      cfg_r.keep_escapes <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aacc_pkg::CfgColumnWidth: cfg_r.column_width <= cfg_data;
        aacc_pkg::CfgPadEnable:   cfg_r.pad_enable   <= cfg_data[0];
        aacc_pkg::CfgKeepEscapes: cfg_r.keep_escapes <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // The payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_kind_r <= in_kind;
      in_byte_r <= in_text_byte;
    end
  end

  aacc_step u_step (
    .kind      (in_kind_r),
    .text_byte (in_byte_r),
    .st        (st_r),
    .cfg       (cfg_r),
    .st_nxt    (st_nxt),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  aacc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (advance ? res_cnt : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (~out_stall),
    .head_valid (q_valid),
    .head       (q_head),
    .room2      (q_room2)
  );

  assign out_valid        = q_valid;
  assign out_char_valid   = q_head.char_valid;
  assign out_char         = q_head.out_char;
  assign out_pad_spaces   = q_head.pad_spaces;
  assign out_reset_needed = q_head.reset_needed;
  assign out_line_done    = q_head.line_done;

`ifndef SYNTHESIS
  // An end-of-line item leaves the line state fully cleared.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_kind_r == aacc_pkg::KindEnd) |=>
      (st_r.shown_count == '0 && !st_r.esc_held && !st_r.in_escape &&
       st_r.clip_mode == aacc_pkg::ClipAccept))
    else $error("line state not cleared after end of line");

  // Once the column is clipped no escape can be open or pending.
  a_clip_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.clip_mode != aacc_pkg::ClipAccept) |-> (!st_r.in_escape && !st_r.esc_held))
    else $error("escape state active while clipped");

  // The end result never carries a character.
  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_done) |-> !out_char_valid)
    else $error("end result marked as a character");

  // No item is taken while the input register is blocked.
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !q_room2) |=> (in_vld_r && $stable(in_byte_r) && $stable(in_kind_r)))
    else $error("held item lost while the queue was full");
`endif

endmodule
`default_nettype wire
